/* rtl/glzw_pkg.sv */
// Shared types and constants for the GIF LZW encoder.
// Holds the controller/datapath command and status structs.
// No dependencies; imported by glzw_ctrl, glzw_dp and the top level.
package glzw_pkg;

    localparam int PIX_W      = 8;
    localparam int ROOT_W     = 4;
    localparam int CW_W       = 4;
    localparam int EPOCH_W    = 4;
    localparam int BUF_W      = 24;
    localparam int CNT_W      = 5;
    localparam int ROOT_MIN   = 2;
    localparam int ROOT_MAX   = 8;
    localparam int ROOT_RESET = 8;
    localparam int REG_ROOT   = 0;

    typedef enum logic [1:0] {
        KIND_ENT = 2'd0,
        KIND_CLR = 2'd1,
        KIND_PFX = 2'd2,
        KIND_END = 2'd3
    } t_kind;

    typedef struct packed {
        logic  take;
        logic  sweep;
        logic  start;
        logic  hash;
        logic  check;
        logic  emit;
        logic  drain;
        logic  upd;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic              need_sweep;
        logic              accepted;
        logic              in_image;
        logic              last;
        logic              hit;
        logic              empty;
        logic              giveup;
        logic              drain_done;
        logic              table_full;
        logic              push;
        logic [CW_W-1:0]   code_width;
    } t_sts;

endpackage

/* rtl/glzw_if.sv */
// Handshake channel interfaces for the GIF LZW encoder.
// Depends on nothing; one interface per channel kind.
interface glzw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       last_pixel;
    modport source (output valid, output pixel, output last_pixel, input ready);
    modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

interface glzw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

/* rtl/glzw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glzw_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 5003
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/glzw_ctrl.sv */
// Sequencing state machine of the GIF LZW encoder.
// Depends on glzw_pkg; drives glzw_dp through t_cmd and reads t_sts.
module glzw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  glzw_pkg::t_sts i_sts,
    output glzw_pkg::t_cmd o_cmd
);
    import glzw_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SWEEP  = 10'b0000000010,
        ST_START  = 10'b0000000100,
        ST_HASH   = 10'b0000001000,
        ST_PROBE  = 10'b0000010000,
        ST_CHECK  = 10'b0000100000,
        ST_EMIT   = 10'b0001000000,
        ST_DRAIN  = 10'b0010000000,
        ST_UPD    = 10'b0100000000,
        ST_FIN    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_sts.need_sweep) begin
                    n_state = ST_SWEEP;
                end else begin
                    o_cmd.take = 1'b1;
                    if (i_sts.accepted) begin
                        n_state = i_sts.in_image ? ST_HASH : ST_START;
                    end
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (!i_sts.need_sweep) n_state = ST_IDLE;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_kind  = KIND_CLR;
                n_state = ST_EMIT;
            end
            ST_HASH: begin
                o_cmd.hash = 1'b1;
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.hit) begin
                    n_state = ST_FIN;
                end else if (i_sts.empty || i_sts.giveup) begin
                    n_kind  = KIND_ENT;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_sts.drain_done) begin
                    case (r_kind)
                        KIND_ENT: n_state = ST_UPD;
                        KIND_CLR: n_state = ST_FIN;
                        KIND_PFX: begin
                            n_kind  = KIND_END;
                            n_state = ST_EMIT;
                        end
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_sts.table_full) begin
                    n_kind  = KIND_CLR;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.last) begin
                    n_kind  = KIND_PFX;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_ENT;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end
endmodule

/* rtl/glzw_dp.sv */
// Datapath of the GIF LZW encoder: prefix, dictionary memory, probe, bit packer.
// Depends on glzw_pkg, glzw_if and glzw_ram; commanded by glzw_ctrl.
module glzw_dp #(
    parameter int MAX_CODE_BITS = 12,
    parameter int HASH_SIZE     = 5003
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [glzw_pkg::ROOT_W-1:0]   i_root,
    input  glzw_pkg::t_cmd                i_cmd,
    output glzw_pkg::t_sts                o_sts,
    glzw_pix_if.sink                      i_pix,
    glzw_byte_if.source                   o_byte
);
    import glzw_pkg::*;

    function automatic int calc_shift(input int hs);
        int f;
        int n;
        f = hs;
        n = 0;
        while (f < 65536) begin
            f = f * 2;
            n = n + 1;
        end
        return (n < 8) ? 8 - n : 0;
    endfunction

    localparam int HSHIFT = calc_shift(HASH_SIZE);
    localparam int HIDX_W = $clog2(HASH_SIZE);
    localparam int PCNT_W = $clog2(HASH_SIZE + 1);
    localparam int NFC_W  = MAX_CODE_BITS + 1;
    localparam int KEY_W  = PIX_W + MAX_CODE_BITS;
    localparam int WORD_W = EPOCH_W + KEY_W + MAX_CODE_BITS;
    localparam int RAW_W  = 16;

    logic [PIX_W-1:0]         r_pix;
    logic                     r_last;
    logic [MAX_CODE_BITS-1:0] r_prefix;
    logic [NFC_W-1:0]         r_nfc;
    logic [CW_W-1:0]          r_cw;
    logic [BUF_W-1:0]         r_buf;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_in_image;
    logic                     r_clr_pend;
    logic                     r_end;
    logic [HIDX_W-1:0]        r_idx;
    logic [HIDX_W-1:0]        r_disp;
    logic [PCNT_W-1:0]        r_pcnt;
    logic                     r_slot_ok;
    logic [EPOCH_W-1:0]       r_epoch;
    logic                     r_need_sweep;
    logic [HIDX_W-1:0]        r_saddr;
    logic                     r_ovalid;
    logic [7:0]               r_obyte;
    logic                     r_olast;

    // Root size clamp and the codes that follow from it.
    logic [ROOT_W-1:0]        rb;
    logic [PIX_W:0]           clear_code;
    logic [PIX_W-1:0]         pix_mask;
    logic [CW_W-1:0]          root_cw;

    always_comb begin
        if (i_root < ROOT_W'(ROOT_MIN))      rb = ROOT_W'(ROOT_MIN);
        else if (i_root > ROOT_W'(ROOT_MAX)) rb = ROOT_W'(ROOT_MAX);
        else                                 rb = i_root;
    end
    assign clear_code = (PIX_W+1)'(1) << rb;
    assign pix_mask   = PIX_W'(clear_code - (PIX_W+1)'(1));
    assign root_cw    = CW_W'(rb + ROOT_W'(1));

    // Dictionary word: epoch tag, key, code.
    logic [WORD_W-1:0]        rdata;
    logic [EPOCH_W-1:0]       rd_tag;
    logic [KEY_W-1:0]         rd_key;
    logic [MAX_CODE_BITS-1:0] rd_code;
    logic [KEY_W-1:0]         key;
    logic                     rd_valid;
    logic                     hit;
    logic                     empty;
    logic                     giveup;

    assign {rd_tag, rd_key, rd_code} = rdata;
    assign key      = {r_pix, r_prefix};
    assign rd_valid = (rd_tag == r_epoch);
    assign hit      = rd_valid && (rd_key == key);
    assign empty    = !rd_valid;
    assign giveup   = !hit && !empty && (r_pcnt == PCNT_W'(HASH_SIZE));

    // First probe: xor of shifted pixel and prefix, folded once into the table.
    logic [RAW_W-1:0]  raw;
    logic [RAW_W-1:0]  raw_mod;
    logic [HIDX_W-1:0] h0;
    logic [HIDX_W-1:0] d0;

    assign raw     = (RAW_W'(r_pix) << HSHIFT) ^ RAW_W'(r_prefix);
    assign raw_mod = (raw >= RAW_W'(HASH_SIZE)) ? raw - RAW_W'(HASH_SIZE) : raw;
    assign h0      = HIDX_W'(raw_mod);
    assign d0      = (h0 == '0) ? HIDX_W'(1) : HIDX_W'(HASH_SIZE) - h0;

    logic [HIDX_W:0]   wrap_sum;
    logic [HIDX_W-1:0] next_idx;

    assign wrap_sum = {1'b0, r_idx} + (HIDX_W+1)'(HASH_SIZE) - {1'b0, r_disp};
    assign next_idx = (r_idx >= r_disp) ? r_idx - r_disp : HIDX_W'(wrap_sum);

    // Code packing.
    logic [MAX_CODE_BITS-1:0] code_sel;
    logic [CW_W-1:0]          w;
    logic [MAX_CODE_BITS:0]   wmask;
    logic [MAX_CODE_BITS-1:0] code_m;
    logic [NFC_W-1:0]         max_code;

    always_comb begin
        case (i_cmd.kind)
            KIND_CLR: code_sel = MAX_CODE_BITS'(clear_code);
            KIND_END: code_sel = MAX_CODE_BITS'(clear_code + (PIX_W+1)'(1));
            default:  code_sel = r_prefix;
        endcase
    end
    assign w      = (r_cw > CW_W'(MAX_CODE_BITS)) ? CW_W'(MAX_CODE_BITS) : r_cw;
    assign wmask  = ((MAX_CODE_BITS+1)'(1) << w) - (MAX_CODE_BITS+1)'(1);
    assign code_m = code_sel & wmask[MAX_CODE_BITS-1:0];
    assign max_code = (r_cw >= CW_W'(MAX_CODE_BITS)) ? NFC_W'(1) << MAX_CODE_BITS
                    : (NFC_W'(1) << r_cw) - NFC_W'(1);

    logic table_full;
    logic drain_done;
    logic slot_free;
    logic push;
    logic [CNT_W-1:0] cnt_after;

    assign table_full = (r_nfc >= (NFC_W'(1) << MAX_CODE_BITS));
    assign drain_done = r_end ? (r_cnt == '0) : (r_cnt < CNT_W'(8));
    assign slot_free  = !r_ovalid || o_byte.ready;
    assign push       = i_cmd.drain && !drain_done && slot_free;
    assign cnt_after  = (r_cnt >= CNT_W'(8)) ? r_cnt - CNT_W'(8) : '0;

    // Memory ports.
    logic                     we;
    logic [HIDX_W-1:0]        waddr;
    logic [WORD_W-1:0]        wdata;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = {r_epoch, key, r_nfc[MAX_CODE_BITS-1:0]};
        if (i_cmd.sweep && r_need_sweep) begin
            we    = 1'b1;
            waddr = r_saddr;
            wdata = '0;
        end else if (i_cmd.upd && !table_full && r_slot_ok) begin
            we = 1'b1;
        end
    end

    glzw_ram #(.WIDTH(WORD_W), .DEPTH(HASH_SIZE)) u_dict (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    logic accepted;
    assign accepted = i_pix.valid && i_cmd.take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix        <= '0;
            r_last       <= 1'b0;
            r_prefix     <= '0;
            r_nfc        <= '0;
            r_cw         <= CW_W'(ROOT_RESET + 1);
            r_buf        <= '0;
            r_cnt        <= '0;
            r_in_image   <= 1'b0;
            r_clr_pend   <= 1'b0;
            r_end        <= 1'b0;
            r_idx        <= '0;
            r_disp       <= '0;
            r_pcnt       <= '0;
            r_slot_ok    <= 1'b0;
            r_epoch      <= EPOCH_W'(1);
            r_need_sweep <= 1'b1;
            r_saddr      <= '0;
            r_ovalid     <= 1'b0;
            r_obyte      <= '0;
            r_olast      <= 1'b0;
        end else begin
            if (accepted) begin
                r_pix  <= i_pix.pixel & pix_mask;
                r_last <= i_pix.last_pixel;
            end
            if (i_cmd.sweep && r_need_sweep) begin
                if (r_saddr == HIDX_W'(HASH_SIZE - 1)) begin
                    r_saddr      <= '0;
                    r_need_sweep <= 1'b0;
                end else begin
                    r_saddr <= r_saddr + HIDX_W'(1);
                end
            end
            if (i_cmd.start) begin
                r_cw       <= root_cw;
                r_clr_pend <= 1'b0;
                r_nfc      <= NFC_W'(clear_code) + NFC_W'(2);
                r_buf      <= '0;
                r_cnt      <= '0;
                r_prefix   <= MAX_CODE_BITS'(r_pix);
                r_in_image <= 1'b1;
                if (r_epoch == '1) begin
                    r_epoch      <= EPOCH_W'(1);
                    r_need_sweep <= 1'b1;
                end else begin
                    r_epoch <= r_epoch + EPOCH_W'(1);
                end
            end
            if (i_cmd.hash) begin
                r_idx  <= h0;
                r_disp <= d0;
                r_pcnt <= '0;
            end
            if (i_cmd.check) begin
                if (hit) begin
                    r_prefix <= rd_code;
                end else if (empty || giveup) begin
                    r_slot_ok <= empty;
                end else begin
                    r_idx  <= next_idx;
                    r_pcnt <= r_pcnt + PCNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_buf <= r_buf | (BUF_W'(code_m) << r_cnt);
                r_cnt <= r_cnt + CNT_W'(w);
                r_end <= (i_cmd.kind == KIND_END);
                if (r_clr_pend) begin
                    r_cw       <= root_cw;
                    r_clr_pend <= 1'b0;
                end else if (r_nfc > max_code && r_cw < CW_W'(MAX_CODE_BITS)) begin
                    r_cw <= r_cw + CW_W'(1);
                end
                if (i_cmd.kind == KIND_END) begin
                    r_in_image <= 1'b0;
                end
            end
            if (i_cmd.upd) begin
                r_prefix <= MAX_CODE_BITS'(r_pix);
                if (!table_full) begin
                    r_nfc <= r_nfc + NFC_W'(1);
                end else begin
                    r_nfc      <= NFC_W'(clear_code) + NFC_W'(2);
                    r_clr_pend <= 1'b1;
                    if (r_epoch == '1) begin
                        r_epoch      <= EPOCH_W'(1);
                        r_need_sweep <= 1'b1;
                    end else begin
                        r_epoch <= r_epoch + EPOCH_W'(1);
                    end
                end
            end
            if (push) begin
                r_ovalid <= 1'b1;
                r_obyte  <= r_buf[7:0];
                r_olast  <= r_end && (cnt_after == '0);
                r_buf    <= r_buf >> 8;
                r_cnt    <= r_end ? cnt_after : r_cnt - CNT_W'(8);
            end else if (o_byte.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign i_pix.ready      = i_cmd.take;
    assign o_byte.valid     = r_ovalid;
    assign o_byte.code_byte = r_obyte;
    assign o_byte.last_byte = r_olast;

    always_comb begin
        o_sts            = '0;
        o_sts.need_sweep = r_need_sweep;
        o_sts.accepted   = accepted;
        o_sts.in_image   = r_in_image;
        o_sts.last       = r_last;
        o_sts.hit        = hit;
        o_sts.empty      = empty;
        o_sts.giveup     = giveup;
        o_sts.drain_done = drain_done;
        o_sts.table_full = table_full;
        o_sts.push       = push;
        o_sts.code_width = r_cw;
    end
endmodule

/* rtl/gif_lzw_encoder_core.sv */
// Top level of the GIF LZW encoder: APB register, controller and datapath.
// Depends on glzw_pkg, glzw_if, glzw_ram, glzw_ctrl and glzw_dp.
//
// The encoder takes one pixel index per input beat and produces the GIF LZW
// code stream, packed LSB-first, one byte per output beat; the final byte of
// an image carries last_byte. The first pixel of an image emits a clear code,
// and a pixel flagged last_pixel flushes the prefix, the end code and the
// padded tail. Pixels are handled one at a time. A pixel that extends the
// prefix passes through accept, hash, dictionary read, compare and a finishing
// step. Each hash collision adds another registered dictionary read and
// compare. A pixel that ends a string adds an emit step, a drain step that
// pushes each full output byte (longer if the sink stalls) and an update step
// for the dictionary write. The dictionary is one single-port-write RAM of
// HASH_SIZE words, each tagged with a 4-bit epoch so that a dictionary clear
// is a single tag increment. After reset, and after every fifteenth clear, a
// clearing pass rewrites the tags of all HASH_SIZE words while no pixel is
// accepted; register writes are taken as usual. root_code_size sits at APB
// byte address 0 and should only be written while the encoder is idle.
module gif_lzw_encoder_core #(
    parameter int MAX_CODE_BITS = 12,
    parameter int HASH_SIZE     = 5003
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    glzw_pix_if.sink    i_pix,
    glzw_byte_if.source o_byte
);
    import glzw_pkg::*;

    logic [ROOT_W-1:0] r_root;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              cfg_wr;

    // Root code size register; the datapath clamps it into range.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 2'(REG_ROOT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= ROOT_W'(ROOT_RESET);
        end else if (cfg_wr) begin
            r_root <= pwdata[ROOT_W-1:0];
        end
    end

    assign prdata = (paddr == 2'(REG_ROOT)) ? 32'(r_root) : '0;

    glzw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    glzw_dp #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .HASH_SIZE     (HASH_SIZE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_root  (r_root),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_pix   (i_pix),
        .o_byte  (o_byte)
    );

    // No pixel may enter while stale dictionary tags are still being cleared.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |-> !w_sts.need_sweep)
        else $error("pixel accepted during dictionary clearing pass");

    // Bytes leave the packer only while the controller drains.
    a_push_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.push |-> w_cmd.drain)
        else $error("byte pushed outside a drain step");

    // Code width never grows past the maximum code size.
    a_width_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> (w_sts.code_width <= CW_W'(MAX_CODE_BITS)))
        else $error("code width exceeds maximum");
endmodule
